/* rtl/core/bfcm_pkg.sv */
package bfcm_pkg;

  localparam int unsigned DepthBits = 8;
  localparam int unsigned PosBits   = 5;
  localparam int unsigned NumCmds   = 3;

  localparam logic [DepthBits-1:0] DepthMax = {DepthBits{1'b1}};
  localparam logic [PosBits-1:0]   PosMax   = {PosBits{1'b1}};

  localparam logic [7:0] ChOpen  = 8'h7B;
  localparam logic [7:0] ChClose = 8'h7D;

  // Command texts, left aligned, zero padded to 20 characters
  localparam logic [159:0] TxtOpen   = {"{\"COMMAND\":\"OPEN\"}", 16'h0000};
  localparam logic [159:0] TxtClose  = {"{\"COMMAND\":\"CLOSE\"}", 8'h00};
  localparam logic [159:0] TxtToggle = "{\"COMMAND\":\"TOGGLE\"}";

  localparam logic [9:0]  DutyFull  = 10'd1000;
  // ceil(2^36 / 1000): exact floor(x / 1000) for every x below 2^26
  localparam logic [26:0] RecipK    = 27'd68719477;
  localparam int unsigned RecipSh   = 36;

  localparam logic [15:0] PeriodRst = 16'd20000;
  localparam logic [9:0]  OpenRst   = 10'd60;
  localparam logic [9:0]  CloseRst  = 10'd90;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_TOGGLE  = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_PERIOD     = 2'd0,
    REG_OPEN_DUTY  = 2'd1,
    REG_CLOSE_DUTY = 2'd2
  } reg_e;

  // Frame decision handed to the scaling pipeline
  typedef struct packed {
    logic        valid;
    cmd_e        cmd;
    logic        update;
    logic [15:0] period;
    logic [9:0]  duty;
  } frame_res_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } scale_stat_t;

  function automatic logic [5:0] cmd_len(input logic [1:0] k);
    logic [5:0] len;
    unique case (k)
      2'd0:    len = 6'd18;
      2'd1:    len = 6'd19;
      default: len = 6'd20;
    endcase
    return len;
  endfunction

  // Character at position p of command k, zero past the end of the text
  function automatic logic [7:0] cmd_byte(input logic [1:0] k, input logic [PosBits-1:0] p);
    logic [159:0] txt;
    logic [7:0]   ch;
    unique case (k)
      2'd0:    txt = TxtOpen;
      2'd1:    txt = TxtClose;
      default: txt = TxtToggle;
    endcase
    if (p < PosBits'(20)) begin
      ch = txt[159 - 8*int'(p) -: 8];
    end else begin
      ch = 8'h00;
    end
    return ch;
  endfunction

endpackage

/* rtl/core/bfcm_matcher.sv */
module bfcm_matcher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                take_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [15:0]         pwm_period_i,
  input  logic [9:0]          open_duty_i,
  input  logic [9:0]          close_duty_i,
  output bfcm_pkg::frame_res_t res_o
);
  import bfcm_pkg::*;

  logic [DepthBits-1:0] depth_q, depth_d;
  logic [PosBits-1:0]   pos_q, pos_d;
  logic [NumCmds-1:0]   flags_q, flags_d;
  logic                 ended_q, ended_d;
  frame_res_t           res_q, res_d;

  logic [NumCmds-1:0]   fl_match, fl_final;
  logic                 ended_m;
  logic [5:0]           pos_next_ext;

  always_comb begin
    depth_d = depth_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    ended_d = ended_q;
    res_d   = '0;
    res_d.cmd = CMD_UNKNOWN;

    fl_match     = flags_q;
    ended_m      = ended_q;
    pos_next_ext = {1'b0, pos_q} + 6'd1;
    fl_final     = '0;

    if (!ended_q) begin
      if (rx_byte_i == 8'h00) begin
        ended_m = 1'b1;
        for (int k = 0; k < NumCmds; k++) begin
          if (cmd_len(2'(k)) != {1'b0, pos_q}) fl_match[k] = 1'b0;
        end
      end else begin
        for (int k = 0; k < NumCmds; k++) begin
          if (cmd_byte(2'(k), pos_q) != rx_byte_i) fl_match[k] = 1'b0;
        end
      end
    end

    fl_final = fl_match;
    if (!ended_m) begin
      for (int k = 0; k < NumCmds; k++) begin
        if (cmd_len(2'(k)) != pos_next_ext) fl_final[k] = 1'b0;
      end
    end

    if (take_i && (pos_q != '0 || rx_byte_i == ChOpen)) begin
      flags_d = fl_match;
      ended_d = ended_m;
      pos_d   = (pos_q == PosMax) ? PosMax : pos_q + PosBits'(1);
      if (rx_byte_i == ChOpen) begin
        if (depth_q != DepthMax) depth_d = depth_q + DepthBits'(1);
      end else if (rx_byte_i == ChClose) begin
        if (depth_q <= DepthBits'(1)) begin
          // frame closes: report and clear
          res_d.valid  = 1'b1;
          res_d.update = 1'b1;
          res_d.period = pwm_period_i;
          priority if (fl_final[0]) begin
            res_d.cmd  = CMD_OPEN;
            res_d.duty = open_duty_i;
          end else if (fl_final[1]) begin
            res_d.cmd  = CMD_CLOSE;
            res_d.duty = close_duty_i;
          end else if (fl_final[2]) begin
            res_d.cmd  = CMD_TOGGLE;
            res_d.duty = close_duty_i;
          end else begin
            res_d.cmd    = CMD_UNKNOWN;
            res_d.update = 1'b0;
            res_d.period = '0;
            res_d.duty   = '0;
          end
          depth_d = '0;
          pos_d   = '0;
          flags_d = '1;
          ended_d = 1'b0;
        end else begin
          depth_d = depth_q - DepthBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      pos_q   <= '0;
      flags_q <= '1;
      ended_q <= 1'b0;
      res_q   <= '0;
    end else if (en_i) begin
      depth_q <= depth_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      ended_q <= ended_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/bfcm_scale.sv */
module bfcm_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  bfcm_pkg::frame_res_t res_i,
  output logic                 valid_o,
  output bfcm_pkg::cmd_e       cmd_o,
  output logic                 update_o,
  output logic [15:0]          compare_o,
  output bfcm_pkg::scale_stat_t stat_o
);
  import bfcm_pkg::*;

  logic        v2_q, v3_q;
  cmd_e        cmd2_q, cmd3_q;
  logic        upd2_q, upd3_q;
  logic [25:0] prod_q, prod_d;
  logic [52:0] quot_q, quot_d;
  logic [9:0]  duty_sat;

  always_comb begin
    duty_sat = (res_i.duty > DutyFull) ? DutyFull : res_i.duty;
    prod_d   = 26'(res_i.period) * 26'(DutyFull - duty_sat);
    quot_d   = 53'(prod_q) * 53'(RecipK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= res_i.valid;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd2_q <= res_i.cmd;
      upd2_q <= res_i.update;
      prod_q <= prod_d;
      cmd3_q <= cmd2_q;
      upd3_q <= upd2_q;
      quot_q <= quot_d;
    end
  end

  assign valid_o   = v3_q;
  assign cmd_o     = cmd3_q;
  assign update_o  = upd3_q;
  assign compare_o = quot_q[RecipSh +: 16];
  assign stat_o    = '{s1_valid: res_i.valid, s2_valid: v2_q};

endmodule

/* rtl/core/brace_frame_command_matcher_core.sv */
// Path: the result of the closing '}' is registered in the matcher, then in the product and
// quotient registers of the scale block, before it appears on the master side.
// Throughput: one byte per cycle; the whole pipeline stalls only while a result waits.
// Stages: frame matcher, period*(1000-duty) multiply, reciprocal multiply by 1/1000.
// Reset (rst_ni low, asynchronous): no frame open, depth zero, all commands candidates,
// pipeline empty, registers back to period 20000, open duty 60, close duty 90.
module brace_frame_command_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [1:0] command_code, [2] servo_update,
                                      // [18:3] servo_compare, [23:19] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bfcm_pkg::*;

  logic [15:0] period_q;
  logic [9:0]  open_duty_q, close_duty_q;
  logic        en;
  frame_res_t  res;
  cmd_e        cmd;
  logic        update;
  logic [15:0] compare;
  scale_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= PeriodRst;
      open_duty_q  <= OpenRst;
      close_duty_q <= CloseRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_PERIOD:     period_q     <= cfg_data_i;
        REG_OPEN_DUTY:  open_duty_q  <= cfg_data_i[9:0];
        REG_CLOSE_DUTY: close_duty_q <= cfg_data_i[9:0];
        default:        ;
      endcase
    end
  end

  // advance everything unless a result is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  bfcm_matcher u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .take_i       (s_axis_tvalid),
    .rx_byte_i    (s_axis_tdata),
    .pwm_period_i (period_q),
    .open_duty_i  (open_duty_q),
    .close_duty_i (close_duty_q),
    .res_o        (res)
  );

  bfcm_scale u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .res_i     (res),
    .valid_o   (m_axis_tvalid),
    .cmd_o     (cmd),
    .update_o  (update),
    .compare_o (compare),
    .stat_o    (stat)
  );

  assign m_axis_tdata = {5'b0, compare, update, cmd};

  a_update_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (update == (cmd != CMD_UNKNOWN)))
    else $error("servo update disagrees with command code");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !update) |-> (compare == 16'd0))
    else $error("nonzero compare without update");

  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.s2_valid && en) |=> m_axis_tvalid)
    else $error("result lost between scale stages");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.s1_valid && !en) |=> stat.s1_valid)
    else $error("frame result dropped during stall");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

import bfcm_pkg::*;

class frame_scoreboard;
  typedef struct packed {
    cmd_e        code;
    logic        update;
    logic [15:0] compare;
  } servo_res_t;

  logic [15:0]  period     = PeriodRst;
  logic [9:0]   open_duty  = OpenRst;
  logic [9:0]   close_duty = CloseRst;

  logic [DepthBits-1:0] depth = '0;
  logic [PosBits-1:0]   pos   = '0;
  logic [2:0]           cand  = 3'b111;
  logic                 ended = 1'b0;

  servo_res_t pending_q[$];
  int errors = 0;

  function string cmd_text(int k);
    string t;
    case (k)
      0:       t = "{\"COMMAND\":\"OPEN\"}";
      1:       t = "{\"COMMAND\":\"CLOSE\"}";
      default: t = "{\"COMMAND\":\"TOGGLE\"}";
    endcase
    return t;
  endfunction

  function void set_reg(reg_e idx, logic [15:0] v);
    case (idx)
      REG_PERIOD:     period = v;
      REG_OPEN_DUTY:  open_duty = v[9:0];
      REG_CLOSE_DUTY: close_duty = v[9:0];
      default: ;
    endcase
  endfunction

  function logic [15:0] scaled(logic [9:0] duty);
    longint d;
    d = (duty > 10'd1000) ? 1000 : longint'(duty);
    return 16'((longint'(period) * (1000 - d)) / 1000);
  endfunction

  // Returns 1 when the byte was taken into a frame
  function bit note_byte(logic [7:0] b);
    int p;
    string t;
    servo_res_t r;
    if (pos == '0 && b != ChOpen) return 1'b0;
    p = int'(pos);
    if (!ended) begin
      if (b == 8'h00) begin
        ended = 1'b1;
        for (int k = 0; k < 3; k++) begin
          t = cmd_text(k);
          if (t.len() != p) cand[k] = 1'b0;
        end
      end else begin
        for (int k = 0; k < 3; k++) begin
          t = cmd_text(k);
          if (p >= t.len()) cand[k] = 1'b0;
          else if (t[p] != b) cand[k] = 1'b0;
        end
      end
    end
    pos = (pos < PosMax) ? pos + 1'b1 : PosMax;
    if (b == ChOpen) begin
      if (depth < DepthMax) depth = depth + 1'b1;
      return 1'b1;
    end
    if (b != ChClose) return 1'b1;
    if (depth != '0) depth = depth - 1'b1;
    if (depth != '0) return 1'b1;
    // frame closes: length must match unless a zero byte already ended the text
    if (!ended) begin
      for (int k = 0; k < 3; k++) begin
        t = cmd_text(k);
        if (t.len() != p + 1) cand[k] = 1'b0;
      end
    end
    if (cand[0]) begin
      r.code = CMD_OPEN;   r.update = 1'b1; r.compare = scaled(open_duty);
    end else if (cand[1]) begin
      r.code = CMD_CLOSE;  r.update = 1'b1; r.compare = scaled(close_duty);
    end else if (cand[2]) begin
      r.code = CMD_TOGGLE; r.update = 1'b1; r.compare = scaled(close_duty);
    end else begin
      r.code = CMD_UNKNOWN; r.update = 1'b0; r.compare = 16'h0000;
    end
    pending_q.push_back(r);
    depth = '0;
    pos   = '0;
    cand  = 3'b111;
    ended = 1'b0;
    return 1'b1;
  endfunction

  task report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [23:0] d);
    servo_res_t e;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("result %h with none pending", d));
      return;
    end
    e = pending_q.pop_front();
    if (d[1:0] != e.code)
      report_mismatch($sformatf("command_code %0d, want %0d", d[1:0], e.code));
    if (d[2] != e.update)
      report_mismatch($sformatf("servo_update %0b, want %0b", d[2], e.update));
    if (d[18:3] != e.compare)
      report_mismatch($sformatf("servo_compare %0d, want %0d", d[18:3], e.compare));
  endtask
endclass

module tb_top;
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [15:0] cfg_data_i    = 16'h0000;

  frame_scoreboard frames = new();

  int burst_left = 0;
  int taken_cnt  = 0;
  int rx_mode    = 0;
  int mode_cnt   = 0;

  brace_frame_command_matcher_core uut (.*);

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver stall pattern: switch between always ready, random and long stalls
  always @(negedge clk_i) begin
    if (mode_cnt == 0) begin
      rx_mode  = $urandom_range(0, 3);
      mode_cnt = $urandom_range(16, 128);
    end else begin
      mode_cnt--;
    end
    case (rx_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = 1'($urandom_range(0, 1));
      2:       m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = (mode_cnt % 16 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) frames.check_result(m_axis_tdata);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    if (frames.note_byte(b)) taken_cnt++;
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  // Send closing braces until no frame is open
  task automatic close_frame();
    while (frames.pos != '0) send_byte(ChClose);
  endtask

  // Hold the sender and wait for every pending result, then let the pipeline settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (frames.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = v;
    @(posedge clk_i);
    frames.set_reg(idx, v);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == ChOpen || b == ChClose || b == 8'h00) b = 8'h41;
    return b;
  endfunction

  task automatic random_sequence();
    int kind, k, n, m;
    string t;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, 2);
    t    = frames.cmd_text(k);
    if (kind < 40) begin
      close_frame();
      send_text(t);
    end else if (kind < 52) begin
      // one byte replaced by a random one
      close_frame();
      n = $urandom_range(0, t.len() - 1);
      for (int i = 0; i < t.len(); i++) begin
        b = (i == n) ? 8'($urandom) : 8'(t[i]);
        send_byte(b);
      end
    end else if (kind < 60) begin
      close_frame();
      n = $urandom_range(1, t.len() - 2);
      for (int i = 0; i < n; i++) send_byte(t[i]);
      send_byte(ChClose);
    end else if (kind < 66) begin
      close_frame();
      for (int i = 0; i < t.len() - 1; i++) send_byte(t[i]);
      m = $urandom_range(1, 15);
      repeat (m) send_byte(rand_plain());
      send_byte(ChClose);
    end else if (kind < 74) begin
      // zero byte ends the compared text
      close_frame();
      n = $urandom_range(1, t.len() - 1);
      for (int i = 0; i < n; i++) send_byte(t[i]);
      send_byte(8'h00);
      m = $urandom_range(0, 5);
      repeat (m) send_byte(8'($urandom));
      close_frame();
    end else if (kind < 82) begin
      close_frame();
      send_byte(ChOpen);
      m = $urandom_range(0, 10);
      repeat (m) begin
        case ($urandom_range(0, 2))
          0:       send_byte(ChOpen);
          1:       send_byte(ChClose);
          default: send_byte(rand_plain());
        endcase
      end
      close_frame();
    end else if (kind < 88) begin
      // long frame, position saturates
      close_frame();
      send_byte(ChOpen);
      m = $urandom_range(30, 40);
      repeat (m) send_byte(rand_plain());
      send_byte(ChClose);
    end else if (kind < 94) begin
      close_frame();
      m = $urandom_range(1, 8);
      repeat (m) begin
        b = 8'($urandom);
        if (b == ChOpen) b = ChClose;
        send_byte(b);
      end
    end else begin
      m = $urandom_range(1, 8);
      repeat (m) send_byte(8'($urandom));
    end
  endtask

  task automatic random_phase(input int target);
    int start;
    start = taken_cnt;
    while (taken_cnt - start < target) random_sequence();
    close_frame();
  endtask

  initial begin
    logic [15:0] p;
    logic [9:0]  o, c;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle bytes and a stray close outside a frame, then an OPEN command, an empty frame and a zero byte frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChClose);
    send_text(frames.cmd_text(0));
    send_byte(ChOpen);
    send_byte(ChClose);
    send_byte(ChOpen);
    send_byte(8'h00);
    send_byte(ChClose);

    // deep nesting: depth saturates, then unwinds from the maximum
    repeat (260) send_byte(ChOpen);
    close_frame();

    random_phase(40);
    drain();

    for (int ph = 1; ph < 7; ph++) begin
      case (ph)
        1: begin p = 16'd65535; o = 10'd0;    c = 10'd1000; end
        2: begin p = 16'd1;     o = 10'd1000; c = 10'd0;    end
        3: begin p = 16'd0;     o = 10'd1023; c = 10'd1001; end
        4: begin p = 16'd65535; o = 10'd999;  c = 10'd1;    end
        default: begin
          p = 16'($urandom_range(1, 65535));
          o = 10'($urandom_range(0, 1000));
          c = 10'($urandom_range(0, 1000));
        end
      endcase
      write_reg(REG_PERIOD, p);
      write_reg(REG_OPEN_DUTY, 16'(o));
      write_reg(REG_CLOSE_DUTY, 16'(c));
      @(negedge clk_i);
      cfg_we_i = 1'b0;
      random_phase(22);
      if (ph == 2) drain();
      random_phase(22);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (frames.errors == 0 && frames.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
